### design/ict_pkg.sv
// shared types and constants for the three-channel interval timer
package ict_pkg;

  // counter count limits
  localparam int unsigned MaxCounters  = 3;
  localparam int unsigned NumCountersDef = 3;

  // port and control word codes
  localparam logic [1:0]  CTL_PORT     = 2'd3;
  localparam logic [1:0]  SEL_READBACK = 2'd3;
  localparam logic [15:0] RELOAD_MAX   = 16'hFFFF;
  localparam int unsigned SPK_CHANNEL  = 2;

  // request opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  // access formats from control word bits 5..4
  typedef enum logic [1:0] {
    FMT_LATCH = 2'd0,
    FMT_LSB   = 2'd1,
    FMT_MSB   = 2'd2,
    FMT_BOTH  = 2'd3
  } fmt_e;

  // per-channel command for one request
  typedef struct packed {
    logic       tick;
    logic       rd;
    logic       wr;
    logic       mode_wr;
    logic       readback;
    logic [7:0] data;
  } ch_cmd_t;

  // per-channel status back to the top level
  typedef struct packed {
    logic [7:0] rd_data;
    logic       reload_evt;
  } ch_stat_t;

endpackage

### design/ict_req_if.sv
// request and response channel interfaces of the interval timer
interface ict_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] port;
  logic [7:0] write_data;

  modport source (output valid, output opcode, output port, output write_data, input ready);
  modport sink   (input valid, input opcode, input port, input write_data, output ready);
endinterface

interface ict_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_pulse;
  logic       speaker_bit;

  modport source (output valid, output read_data, output irq_pulse, output speaker_bit,
                  input ready);
  modport sink   (input valid, input read_data, input irq_pulse, input speaker_bit,
                  output ready);
endinterface

### design/interval_timer_three_channel.sv
// top level of the three-channel interval timer
// Takes one request per clock (tick, port read or port write) and returns one response
// per request, after acceptance: the request first sits in the input register, where it
// is decoded and the counters, control byte and speaker bit update, and then passes to
// the response register. With the response side ready the throughput is one request
// per cycle; a stalled response holds the input register, which then backs up the
// request side. The counters step only on tick requests, not on the clock.
module interval_timer_three_channel
  import ict_pkg::*;
#(
  parameter int unsigned NUM_COUNTERS = NumCountersDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ict_req_if.sink       req_i,
  ict_rsp_if.source     rsp_o
);

  localparam logic HasSpk = (NUM_COUNTERS > SPK_CHANNEL);

  logic       in_valid_q;
  opcode_e    op_q;
  logic [1:0] port_q;
  logic [7:0] data_q;
  logic       advance;
  logic       exec;

  logic [7:0] ctl_q, ctl_d;
  logic       spk_q, spk_d;
  logic       out_valid_q;
  logic [7:0] rd_q, rd_d;
  logic       irq_q, irq_d;

  logic [7:0]           rd_all [4];
  logic [MaxCounters-1:0] evt_all;

  // request side handshake
  assign advance     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !in_valid_q || advance;
  assign exec        = in_valid_q && advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q   <= opcode_e'(req_i.opcode);
      port_q <= req_i.port;
      data_q <= req_i.write_data;
    end
  end

  // counter channels
  for (genvar n = 0; n < MaxCounters; n++) begin : g_ch
    if (n < NUM_COUNTERS) begin : g_on
      ch_cmd_t  cmd;
      ch_stat_t stat;

      always_comb begin
        cmd          = '0;
        cmd.data     = data_q;
        cmd.tick     = exec && op_q == OP_TICK;
        cmd.rd       = exec && op_q == OP_READ && port_q == 2'(n);
        cmd.wr       = exec && op_q == OP_WRITE && port_q == 2'(n);
        cmd.mode_wr  = exec && op_q == OP_WRITE && port_q == CTL_PORT
                       && data_q[7:6] == 2'(n);
        cmd.readback = ctl_q[7:6] == SEL_READBACK && ctl_q[3+n];
      end

      ict_channel u_channel (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cmd_i  (cmd),
        .stat_o (stat)
      );

      assign rd_all[n]  = stat.rd_data;
      assign evt_all[n] = stat.reload_evt;
    end else begin : g_off
      assign rd_all[n]  = '0;
      assign evt_all[n] = 1'b0;
    end
  end
  assign rd_all[CTL_PORT] = '0;

  // control byte, speaker toggle and response values
  always_comb begin
    ctl_d = ctl_q;
    spk_d = spk_q;
    rd_d  = '0;
    irq_d = 1'b0;
    unique case (op_q)
      OP_TICK: begin
        irq_d = evt_all[0];
        if (HasSpk && evt_all[SPK_CHANNEL]) begin
          spk_d = !spk_q;
        end
      end
      OP_READ: begin
        rd_d = (port_q == CTL_PORT) ? ctl_q : rd_all[port_q];
      end
      OP_WRITE: begin
        if (port_q == CTL_PORT) begin
          ctl_d = data_q;
        end else if (HasSpk && port_q == 2'(SPK_CHANNEL)) begin
          spk_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // state and response registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= '0;
      spk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (exec) begin
        ctl_q <= ctl_d;
        spk_q <= spk_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      rd_q  <= rd_d;
      irq_q <= irq_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_data   = rd_q;
  assign rsp_o.irq_pulse   = irq_q;
  assign rsp_o.speaker_bit = spk_q;

endmodule

### design/ict_channel.sv
// one 16-bit down-counter with reload, mode byte and byte flip-flop
module ict_channel
  import ict_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ch_cmd_t  cmd_i,
  output ch_stat_t stat_o
);

  logic [15:0] live_q, live_d;
  logic [15:0] reload_q, reload_d;
  logic [7:0]  mode_q, mode_d;
  logic        flip_q, flip_d;
  logic [15:0] wr_val;
  fmt_e        fmt;

  assign fmt = fmt_e'(mode_q[5:4]);

  // next state and read byte
  always_comb begin
    live_d   = live_q;
    reload_d = reload_q;
    mode_d   = mode_q;
    flip_d   = flip_q;
    wr_val   = reload_q;
    stat_o   = '0;

    // reload value built from the written byte
    unique case (fmt)
      FMT_LSB:   wr_val = {reload_q[15:8], cmd_i.data};
      FMT_MSB:   wr_val = {cmd_i.data, reload_q[7:0]};
      FMT_BOTH:  wr_val = flip_q ? {cmd_i.data, reload_q[7:0]}
                                 : {reload_q[15:8], cmd_i.data};
      default:   wr_val = live_q;
    endcase
    if (wr_val == '0) begin
      wr_val = RELOAD_MAX;
    end

    // read byte, with read-back of the mode byte
    if (cmd_i.readback) begin
      stat_o.rd_data = mode_q;
    end else begin
      unique case (fmt)
        FMT_MSB: stat_o.rd_data = live_q[15:8];
        FMT_LSB: stat_o.rd_data = live_q[7:0];
        default: stat_o.rd_data = flip_q ? live_q[15:8] : live_q[7:0];
      endcase
    end

    if (cmd_i.tick) begin
      if (live_q != '0) begin
        live_d = live_q - 16'd1;
      end else begin
        live_d            = reload_q;
        stat_o.reload_evt = 1'b1;
      end
    end

    if (cmd_i.rd && !cmd_i.readback && (fmt == FMT_LATCH || fmt == FMT_BOTH)) begin
      flip_d = !flip_q;
    end

    if (cmd_i.wr) begin
      reload_d = wr_val;
      live_d   = wr_val;
      if (fmt == FMT_BOTH) begin
        flip_d = !flip_q;
      end
    end

    if (cmd_i.mode_wr) begin
      mode_d = cmd_i.data;
      flip_d = 1'b0;
    end
  end

  // counter state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q   <= RELOAD_MAX;
      reload_q <= '0;
      mode_q   <= '0;
      flip_q   <= 1'b0;
    end else begin
      live_q   <= live_d;
      reload_q <= reload_d;
      mode_q   <= mode_d;
      flip_q   <= flip_d;
    end
  end

endmodule
